### rtl/core/plis_pkg.sv
// ----------------------------------------------------------------------------
// plis_pkg: shared types and constants of the posting list intersection core
// Holds table geometry, command and status codes, and the transfer structs.
// ----------------------------------------------------------------------------
`default_nettype none

package plis_pkg;

  // Table geometry. The slot count must be a power of two.
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  // Field widths.
  localparam int KEY_W  = 32;
  localparam int FREQ_W = 20;

  // Multiplicative hash constant.
  localparam logic [KEY_W-1:0]  HASH_MULT = 32'h9E37_79B9;
  localparam logic [FREQ_W-1:0] FREQ_MAX  = {FREQ_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PROBE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    STAT_MATCH = 1'b0,
    STAT_FULL  = 1'b1
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_HASH,
    S_CHECK
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  doc_id;
    logic [FREQ_W-1:0] freq;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [KEY_W-1:0]  doc_id_out;
    logic [FREQ_W-1:0] freq_sum;
  } result_t;

  // One hash table slot as stored in memory.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [FREQ_W-1:0] freq;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/plis_table.sv
// ----------------------------------------------------------------------------
// plis_table: hash table slot memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module plis_table (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire  [plis_pkg::IDX_W-1:0]  wr_addr,
  input  plis_pkg::entry_t            wr_data,
  input  wire  [plis_pkg::IDX_W-1:0]  rd_addr,
  output plis_pkg::entry_t            rd_data
);
  import plis_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/posting_list_intersect_sum_core.sv
// ----------------------------------------------------------------------------
// posting_list_intersect_sum_core: hash join of two posting lists
// Loads one list into an open-addressing table and probes it with the other.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers when start is high and busy is low. CMD_CLEAR empties
//   the table, CMD_LOAD inserts or overwrites a (doc_id, freq) pair, and
//   CMD_PROBE looks up a doc_id. CMD_NONE is taken and ignored.
//   A result appears on result for exactly one cycle with valid high: a probe
//   hit gives the id and the saturated frequency sum, and a load of a new id
//   into a full table gives status STAT_FULL. The receiver cannot stall; the
//   result register is written only for these two results, and busy stays
//   high until the command is finished.
//   Sequence: a load or probe reads the home slot in S_HASH, then walks 1 up
//   to TABLE_ENTRIES slots in S_CHECK; a probe of an empty table ends in
//   S_HASH. The result strobe comes in the cycle after the last slot is
//   checked. The walk is bound by the single read port of the slot memory:
//   one slot per cycle. A clear sweeps the valid bits one slot a cycle over
//   all TABLE_ENTRIES slots; after reset the same sweep runs (busy high).
// ----------------------------------------------------------------------------
`default_nettype none

module posting_list_intersect_sum_core (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  plis_pkg::item_t   item,
  output logic              busy,
  output logic              valid,
  output plis_pkg::result_t result
);
  import plis_pkg::*;

  state_t              state, state_next;
  logic [IDX_W-1:0]    slot, slot_next;
  logic [IDX_W-1:0]    step, step_next;
  logic [CNT_W-1:0]    entry_count, entry_count_next;
  cmd_t                cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [FREQ_W-1:0]   freq_q;
  logic                valid_next;
  result_t             result_next;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;
  logic [IDX_W-1:0]    rd_addr;
  entry_t              rd_data;

  logic [KEY_W-1:0]    hash_prod;
  logic [IDX_W-1:0]    home;
  logic                hit;
  logic [FREQ_W:0]     sum_raw;
  logic [FREQ_W-1:0]   sum_sat;
  logic                accept;

  plis_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Home slot: low bits of the multiplicative hash.
  assign hash_prod = key_q * HASH_MULT;
  assign home      = hash_prod[IDX_W-1:0];

  // Slot compare and saturated sum on the read data.
  assign hit     = rd_data.valid && (rd_data.key == key_q);
  assign sum_raw = {1'b0, rd_data.freq} + {1'b0, freq_q};
  assign sum_sat = sum_raw[FREQ_W] ? FREQ_MAX : sum_raw[FREQ_W-1:0];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Command register, loaded on each transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= item.cmd;
      key_q  <= item.doc_id;
      freq_q <= item.freq;
    end
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      slot        <= '0;
      step        <= '0;
      entry_count <= '0;
      valid       <= 1'b0;
    end else begin
      state       <= state_next;
      slot        <= slot_next;
      step        <= step_next;
      entry_count <= entry_count_next;
      valid       <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Next state, table accesses and result.
  always_comb begin
    state_next       = state;
    slot_next        = slot;
    step_next        = step;
    entry_count_next = entry_count;
    valid_next       = 1'b0;
    result_next      = result;
    wr_en            = 1'b0;
    wr_addr          = slot;
    wr_data          = '{valid: 1'b1, key: key_q, freq: freq_q};
    rd_addr          = slot;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.cmd)
            CMD_CLEAR: begin
              state_next = S_CLEAR;
              slot_next  = '0;
            end
            CMD_LOAD, CMD_PROBE: begin
              state_next = S_HASH;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // Sweep the valid bits, one slot per cycle.
      S_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = slot;
        wr_data.valid = 1'b0;
        slot_next     = slot + 1'b1;
        if (slot == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next       = S_IDLE;
          entry_count_next = '0;
        end
      end

      // Issue the read of the home slot.
      S_HASH: begin
        rd_addr   = home;
        slot_next = home;
        step_next = '0;
        if (cmd_q == CMD_PROBE && entry_count == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_CHECK;
        end
      end

      // Check one slot per cycle and read the next one ahead.
      S_CHECK: begin
        rd_addr = slot + 1'b1;
        priority if (!rd_data.valid) begin
          state_next = S_IDLE;
          if (cmd_q == CMD_LOAD) begin
            wr_en            = 1'b1;
            entry_count_next = entry_count + 1'b1;
          end
        end else if (hit) begin
          state_next = S_IDLE;
          if (cmd_q == CMD_LOAD) begin
            wr_en = 1'b1;
          end else begin
            valid_next  = 1'b1;
            result_next = '{status: STAT_MATCH, doc_id_out: key_q, freq_sum: sum_sat};
          end
        end else if (step == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = S_IDLE;
          if (cmd_q == CMD_LOAD) begin
            valid_next  = 1'b1;
            result_next = '{status: STAT_FULL, doc_id_out: key_q, freq_sum: '0};
          end
        end else begin
          slot_next = slot + 1'b1;
          step_next = step + 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/plis_checker.sv
// ----------------------------------------------------------------------------
// plis_checker: port-level checks of the posting list intersection core
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plis_checker (
  input wire               clk,
  input wire               rst,
  input wire               start,
  input plis_pkg::item_t   item,
  input wire               busy,
  input wire               valid,
  input plis_pkg::result_t result
);
  import plis_pkg::*;

  // The reset sweep keeps the core busy.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("core not busy after reset");

  // A clear, load or probe transfer makes the core busy.
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd != CMD_NONE) |=> busy)
    else $error("command transfer did not raise busy");

  // A result marks the end of a command.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("result strobe while busy");

  // Results never come in adjacent cycles.
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("result strobe longer than one cycle");

  // A table-full status carries a zero sum.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && result.status == STAT_FULL) |-> (result.freq_sum == '0))
    else $error("table-full result with nonzero sum");

endmodule

bind posting_list_intersect_sum_core plis_checker u_plis_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .valid  (valid),
  .result (result)
);

`default_nettype wire
